// ===== src/tnsch_pkg.sv =====
package tnsch_pkg;

    localparam int TRACK_LIMIT_DEF = 64;
    localparam int MAX_ACTIVE_DEF  = 32;

    localparam int SR_W   = 18;
    localparam int BEAT_W = 24;
    localparam int TIU_W  = 7;
    localparam int VOL_W  = 8;
    localparam int UNIT_W = 3;
    localparam int LEN_W  = 16;
    localparam int POS_W  = 64;
    localparam int PROD_W = BEAT_W + LEN_W;

    localparam logic [2:0] REG_SEC_RATE       = 3'd0;
    localparam logic [2:0] REG_BEAT_LENGTH    = 3'd1;
    localparam logic [2:0] REG_TRACKS_IN_USE  = 3'd2;
    localparam logic [2:0] REG_DEFAULT_VOLUME = 3'd3;
    localparam logic [2:0] REG_DEFAULT_UNIT   = 3'd4;
    localparam logic [2:0] REG_DEFAULT_LENGTH = 3'd5;

    localparam logic [SR_W-1:0]   RST_SEC_RATE       = 18'd44100;
    localparam logic [BEAT_W-1:0] RST_BEAT_LENGTH    = 24'd22050;
    localparam logic [TIU_W-1:0]  RST_TRACKS_IN_USE  = 7'd1;
    localparam logic [VOL_W-1:0]  RST_DEFAULT_VOLUME = 8'd128;
    localparam logic [UNIT_W-1:0] RST_DEFAULT_UNIT   = 3'd0;
    localparam logic [LEN_W-1:0]  RST_DEFAULT_LENGTH = 16'd1;

    localparam logic [1:0] EV_ON    = 2'd0;
    localparam logic [1:0] EV_OFF   = 2'd1;
    localparam logic [1:0] EV_AFTER = 2'd2;

    localparam logic [1:0] KIND_OFF = 2'd1;
    localparam logic [1:0] KIND_ON  = 2'd2;

    localparam logic [UNIT_W-1:0] U_BEAT     = 3'd0;
    localparam logic [UNIT_W-1:0] U_BEAT_16  = 3'd1;
    localparam logic [UNIT_W-1:0] U_BEAT_256 = 3'd2;
    localparam logic [UNIT_W-1:0] U_SEC      = 3'd4;
    localparam logic [UNIT_W-1:0] U_SEC_16   = 3'd5;
    localparam logic [UNIT_W-1:0] U_SEC_256  = 3'd6;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_OFF,
        OP_ON,
        OP_VOL
    } op_t;

    typedef struct packed {
        logic [SR_W-1:0]   sec_rate;
        logic [BEAT_W-1:0] beat_length;
        logic [TIU_W-1:0]  tracks_in_use;
        logic [VOL_W-1:0]  default_volume;
        logic [UNIT_W-1:0] default_unit;
        logic [LEN_W-1:0]  default_length;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [5:0]        track;
        logic [7:0]        note_value;
        logic              has_volume;
        logic [VOL_W-1:0]  volume;
        logic              has_unit;
        logic [UNIT_W-1:0] unit;
        logic              has_length;
        logic [LEN_W-1:0]  length;
        logic [15:0]       samples;
    } item_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [7:0]       note;
        logic [VOL_W-1:0] velocity;
        logic             table_full;
        logic             last;
    } event_t;

endpackage

// ===== src/tnsch_front.sv =====
module tnsch_front #(
    parameter int TRACK_LIMIT = tnsch_pkg::TRACK_LIMIT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tnsch_pkg::cfg_t           cfg,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [5:0]                track,
    input  logic [1:0]                note_kind,
    input  logic [7:0]                note_value,
    input  logic                      has_volume,
    input  logic [7:0]                volume,
    input  logic                      has_unit,
    input  logic [2:0]                unit,
    input  logic                      has_length,
    input  logic [15:0]               length,
    input  logic [15:0]               samples,
    input  logic                      skip_time,
    output logic                      q_valid,
    output tnsch_pkg::item_t          q_item,
    input  logic                      q_pop
);
    import tnsch_pkg::*;

    item_t      q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    item_t      cls;
    logic       push;

    always_comb
    begin
        cls.track      = track;
        cls.note_value = note_value;
        cls.has_volume = has_volume;
        cls.volume     = volume;
        cls.has_unit   = has_unit;
        cls.unit       = unit;
        cls.has_length = has_length;
        cls.length     = length;
        cls.samples    = samples;
        if (req_type)
            cls.op = skip_time ? OP_NONE : OP_TICK;
        else if (7'(track) >= cfg.tracks_in_use || 9'(track) >= 9'(TRACK_LIMIT))
            cls.op = OP_NONE;
        else
        begin
            case (note_kind)
                KIND_OFF: cls.op = OP_OFF;
                KIND_ON:  cls.op = OP_ON;
                default:  cls.op = OP_VOL;
            endcase
        end
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== src/tnsch_back.sv =====
module tnsch_back #(
    parameter int TRACK_LIMIT = tnsch_pkg::TRACK_LIMIT_DEF,
    parameter int MAX_ACTIVE  = tnsch_pkg::MAX_ACTIVE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tnsch_pkg::cfg_t     cfg,
    input  logic                q_valid,
    input  tnsch_pkg::item_t    q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output tnsch_pkg::event_t   out_ev
);
    import tnsch_pkg::*;

    localparam int TW = (TRACK_LIMIT > 1) ? $clog2(TRACK_LIMIT) : 1;
    localparam int SW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CW = $clog2(MAX_ACTIVE + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_MUL      = 7'b0001000,
        S_ADD      = 7'b0010000,
        S_FINISH   = 7'b0100000,
        S_SPARE    = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        M_OWNER,
        M_PITCH,
        M_TIME
    } mode_t;

    typedef struct packed {
        logic [7:0]        note;
        logic [VOL_W-1:0]  volume;
        logic [UNIT_W-1:0] unit;
        logic [LEN_W-1:0]  length;
    } trk_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    item_t  cur_reg;

    trk_t   trk_mem [TRACK_LIMIT];
    trk_t   rd_reg;
    trk_t   wr_ent;
    logic   mem_we;

    logic [TRACK_LIMIT-1:0] on_reg, vs_reg, us_reg, ls_reg;

    logic [7:0]       s_note  [MAX_ACTIVE];
    logic [5:0]       s_owner [MAX_ACTIVE];
    logic [POS_W-1:0] s_end   [MAX_ACTIVE];

    logic [POS_W-1:0] pos_reg;
    logic [CW-1:0]    cnt_reg, i_reg, w_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [3:0]        sh_reg;
    logic [VOL_W-1:0]  vel_reg;

    event_t pend_reg;
    logic   pend_valid_reg;
    event_t out_reg;
    logic   out_valid_reg;

    logic   go, fire, flush, push, hit, vol_chg, full;
    event_t ev_new;
    logic [TW-1:0] tidx, oidx;
    logic [SW-1:0] ridx;
    logic [UNIT_W-1:0] u_sel;
    logic [LEN_W-1:0]  l_sel, m_len;
    logic [BEAT_W-1:0] m_base;
    logic [3:0]        m_sh;
    logic [POS_W-1:0]  dur;

    assign tidx    = TW'(cur_reg.track);
    assign ridx    = i_reg[SW-1:0];
    assign oidx    = TW'(s_owner[ridx]);
    assign go      = !pend_valid_reg || !out_valid_reg || !out_stall;
    assign vol_chg = cur_reg.has_volume && (!vs_reg[tidx] || rd_reg.volume != cur_reg.volume);
    assign full    = (cnt_reg == CW'(MAX_ACTIVE));
    assign dur     = POS_W'(prod_reg >> sh_reg);

    always_comb
    begin
        case (mode_reg)
            M_OWNER: hit = (s_owner[ridx] == cur_reg.track);
            M_PITCH: hit = (s_note[ridx] == cur_reg.note_value);
            default: hit = (pos_reg >= s_end[ridx]);
        endcase
    end

    // length lookup: row, then track, then default
    always_comb
    begin
        u_sel = cur_reg.has_unit ? cur_reg.unit :
                (us_reg[tidx] ? rd_reg.unit : cfg.default_unit);
        l_sel = cur_reg.has_length ? cur_reg.length :
                (ls_reg[tidx] ? rd_reg.length : cfg.default_length);
        m_base = BEAT_W'(cfg.sec_rate);
        m_len  = l_sel;
        m_sh   = 4'd0;
        unique case (u_sel)
            U_BEAT:     m_base = cfg.beat_length;
            U_BEAT_16:  begin m_base = cfg.beat_length; m_sh = 4'd4; end
            U_BEAT_256: begin m_base = cfg.beat_length; m_sh = 4'd8; end
            U_SEC:      ;
            U_SEC_16:   m_sh = 4'd4;
            U_SEC_256:  m_sh = 4'd8;
            default:    m_len = LEN_W'(1);
        endcase
    end

    always_comb
    begin
        wr_ent.note   = (cur_reg.op == OP_ON) ? cur_reg.note_value : rd_reg.note;
        wr_ent.volume = (cur_reg.has_volume && cur_reg.op != OP_OFF) ?
                        cur_reg.volume : rd_reg.volume;
        wr_ent.unit   = cur_reg.has_unit ? cur_reg.unit : rd_reg.unit;
        wr_ent.length = cur_reg.has_length ? cur_reg.length : rd_reg.length;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        q_pop      = 1'b0;
        fire       = 1'b0;
        flush      = 1'b0;
        mem_we     = 1'b0;
        ev_new     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_NONE: state_next = S_IDLE;
                        OP_TICK:
                        begin
                            mode_next  = M_TIME;
                            state_next = S_SCAN;
                        end
                        default: state_next = S_DISPATCH;
                    endcase
                end
            end
            S_DISPATCH:
            begin
                if (go)
                begin
                    state_next = S_FINISH;
                    case (cur_reg.op)
                        OP_OFF:
                        begin
                            if (on_reg[tidx])
                            begin
                                mode_next  = M_OWNER;
                                state_next = S_SCAN;
                            end
                        end
                        OP_ON:
                        begin
                            mode_next  = M_PITCH;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (vol_chg && on_reg[tidx])
                            begin
                                fire             = 1'b1;
                                ev_new.event_res = EV_AFTER;
                                ev_new.note      = rd_reg.note;
                                ev_new.velocity  = cur_reg.volume;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (go)
                begin
                    if (i_reg == cnt_reg)
                        state_next = (cur_reg.op == OP_ON) ? S_MUL : S_FINISH;
                    else if (hit)
                    begin
                        fire             = 1'b1;
                        ev_new.event_res = EV_OFF;
                        ev_new.note      = s_note[ridx];
                    end
                end
            end
            S_MUL:
                state_next = S_ADD;
            S_ADD:
            begin
                if (go)
                begin
                    fire              = 1'b1;
                    ev_new.event_res  = EV_ON;
                    ev_new.note       = cur_reg.note_value;
                    ev_new.velocity   = vel_reg;
                    ev_new.table_full = full;
                    state_next        = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (go)
                begin
                    flush      = 1'b1;
                    mem_we     = (cur_reg.op != OP_TICK);
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign push = pend_valid_reg && (fire || flush);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            trk_mem[tidx] <= wr_ent;
        if (state_reg == S_IDLE && q_valid)
            rd_reg <= trk_mem[TW'(q_item.track)];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(m_base) * PROD_W'(m_len);
            sh_reg   <= m_sh;
            vel_reg  <= cur_reg.has_volume ? cur_reg.volume :
                        (vs_reg[tidx] ? rd_reg.volume : cfg.default_volume);
        end
        if (state_reg == S_SCAN && go && i_reg != cnt_reg && !hit)
        begin
            s_note[w_reg[SW-1:0]]  <= s_note[ridx];
            s_owner[w_reg[SW-1:0]] <= s_owner[ridx];
            s_end[w_reg[SW-1:0]]   <= s_end[ridx];
        end
        if (state_reg == S_ADD && go && !full)
        begin
            s_note[cnt_reg[SW-1:0]]  <= cur_reg.note_value;
            s_owner[cnt_reg[SW-1:0]] <= cur_reg.track;
            s_end[cnt_reg[SW-1:0]]   <= pos_reg + dur;
        end
        if (fire)
            pend_reg <= ev_new;
        if (push)
            out_reg <= '{event_res: pend_reg.event_res, note: pend_reg.note,
                         velocity: pend_reg.velocity, table_full: pend_reg.table_full,
                         last: flush};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_TIME;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            on_reg         <= '0;
            vs_reg         <= '0;
            us_reg         <= '0;
            ls_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            if (q_pop && q_item.op == OP_TICK)
                pos_reg <= pos_reg + POS_W'(q_item.samples);
            if (state_next == S_SCAN && state_reg != S_SCAN)
            begin
                i_reg <= '0;
                w_reg <= '0;
            end
            if (state_reg == S_SCAN && go)
            begin
                if (i_reg == cnt_reg)
                    cnt_reg <= w_reg;
                else
                begin
                    i_reg <= i_reg + CW'(1);
                    if (!hit)
                        w_reg <= w_reg + CW'(1);
                    else if (9'(s_owner[ridx]) < 9'(TRACK_LIMIT))
                        on_reg[oidx] <= 1'b0;
                end
            end
            if (state_reg == S_ADD && go)
            begin
                on_reg[tidx] <= 1'b1;
                if (!full)
                    cnt_reg <= cnt_reg + CW'(1);
            end
            if (mem_we)
            begin
                if (cur_reg.has_volume && cur_reg.op != OP_OFF)
                    vs_reg[tidx] <= 1'b1;
                if (cur_reg.has_unit)
                    us_reg[tidx] <= 1'b1;
                if (cur_reg.has_length)
                    ls_reg[tidx] <= 1'b1;
            end
            if (fire)
                pend_valid_reg <= 1'b1;
            else if (flush)
                pend_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_reg;

endmodule

// ===== src/tracker_note_scheduler_core.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------
// input     | in_valid / in_stall       | req_type, track .. skip_time
// output    | out_valid / out_stall     | event_res, note, velocity, table_full, last
// config    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A note-on row scans every active note (up to 32) and then adds its own if the table has room;
// a note-off scans them only on a sounding track; a volume-only row scans none;
// a tick scans them all; a dropped or skipped request is only popped from the queue.
// A stalled output that holds back a waiting event holds the engine as well.
// A two-entry request queue lets the front accept while the engine runs.
// rst_n clears all flags, counts and position; the track memory is not cleared.
// Events are held one deep so the final one of a request can carry last.
module tracker_note_scheduler_core #(
    parameter int TRACK_LIMIT = tnsch_pkg::TRACK_LIMIT_DEF,
    parameter int MAX_ACTIVE  = tnsch_pkg::MAX_ACTIVE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [5:0]  track,
    input  logic [1:0]  note_kind,
    input  logic [7:0]  note_value,
    input  logic        has_volume,
    input  logic [7:0]  volume,
    input  logic        has_unit,
    input  logic [2:0]  unit,
    input  logic        has_length,
    input  logic [15:0] length,
    input  logic [15:0] samples,
    input  logic        skip_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [7:0]  note,
    output logic [7:0]  velocity,
    output logic        table_full,
    output logic        last
);
    import tnsch_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] ridx;
    logic       q_valid, q_pop;
    item_t      q_item;
    event_t     ev;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sec_rate       <= RST_SEC_RATE;
            cfg_reg.beat_length    <= RST_BEAT_LENGTH;
            cfg_reg.tracks_in_use  <= RST_TRACKS_IN_USE;
            cfg_reg.default_volume <= RST_DEFAULT_VOLUME;
            cfg_reg.default_unit   <= RST_DEFAULT_UNIT;
            cfg_reg.default_length <= RST_DEFAULT_LENGTH;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                REG_SEC_RATE:       cfg_reg.sec_rate       <= pwdata[SR_W-1:0];
                REG_BEAT_LENGTH:    cfg_reg.beat_length    <= pwdata[BEAT_W-1:0];
                REG_TRACKS_IN_USE:  cfg_reg.tracks_in_use  <= pwdata[TIU_W-1:0];
                REG_DEFAULT_VOLUME: cfg_reg.default_volume <= pwdata[VOL_W-1:0];
                REG_DEFAULT_UNIT:   cfg_reg.default_unit   <= pwdata[UNIT_W-1:0];
                REG_DEFAULT_LENGTH: cfg_reg.default_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_SEC_RATE:       prdata = 32'(cfg_reg.sec_rate);
            REG_BEAT_LENGTH:    prdata = 32'(cfg_reg.beat_length);
            REG_TRACKS_IN_USE:  prdata = 32'(cfg_reg.tracks_in_use);
            REG_DEFAULT_VOLUME: prdata = 32'(cfg_reg.default_volume);
            REG_DEFAULT_UNIT:   prdata = 32'(cfg_reg.default_unit);
            REG_DEFAULT_LENGTH: prdata = 32'(cfg_reg.default_length);
            default:            prdata = 32'd0;
        endcase
    end

    tnsch_front #(.TRACK_LIMIT(TRACK_LIMIT)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .track      (track),
        .note_kind  (note_kind),
        .note_value (note_value),
        .has_volume (has_volume),
        .volume     (volume),
        .has_unit   (has_unit),
        .unit       (unit),
        .has_length (has_length),
        .length     (length),
        .samples    (samples),
        .skip_time  (skip_time),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    tnsch_back #(.TRACK_LIMIT(TRACK_LIMIT), .MAX_ACTIVE(MAX_ACTIVE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ev    (ev)
    );

    assign event_res  = ev.event_res;
    assign note       = ev.note;
    assign velocity   = ev.velocity;
    assign table_full = ev.table_full;
    assign last       = ev.last;

endmodule

// ===== src/tnsch_checker.sv =====
module tnsch_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] event_res,
    input logic [7:0] note,
    input logic [7:0] velocity,
    input logic       table_full,
    input logic       last
);
    import tnsch_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(note) && $stable(last))
        else $error("stalled event changed");

    a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_OFF |-> velocity == 8'd0 && !table_full)
        else $error("note-off with velocity or full flag");

    a_full_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> event_res == EV_ON)
        else $error("table_full on non note-on");

endmodule

bind tracker_note_scheduler_core tnsch_checker u_tnsch_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .note       (note),
    .velocity   (velocity),
    .table_full (table_full),
    .last       (last)
);

// ===== test/note_event_checker.sv =====
`timescale 1ns / 100ps
module note_event_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [5:0]  track,
    input  logic [1:0]  note_kind,
    input  logic [7:0]  note_value,
    input  logic        has_volume,
    input  logic [7:0]  volume,
    input  logic        has_unit,
    input  logic [2:0]  unit,
    input  logic        has_length,
    input  logic [15:0] length,
    input  logic [15:0] samples,
    input  logic        skip_time,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  event_res,
    input  logic [7:0]  note,
    input  logic [7:0]  velocity,
    input  logic        table_full,
    input  logic        last,
    output int          fail_count,
    output int          pending_events,
    output int          event_total
);
    import tnsch_pkg::*;

    localparam int NT = TRACK_LIMIT_DEF;
    localparam int NA = MAX_ACTIVE_DEF;

    logic [SR_W-1:0]   sr;
    logic [BEAT_W-1:0] beat;
    logic [TIU_W-1:0]  tiu;
    logic [7:0]        dvol;
    logic [2:0]        dunit;
    logic [15:0]       dlen;

    logic [63:0] pos;
    logic        t_on[NT];
    logic [7:0]  t_note[NT];
    logic        t_vs[NT];
    logic [7:0]  t_vol[NT];
    logic        t_us[NT];
    logic [2:0]  t_unit[NT];
    logic        t_ls[NT];
    logic [15:0] t_len[NT];
    int          n_act;
    logic [7:0]  a_note[NA];
    logic [5:0]  a_owner[NA];
    logic [63:0] a_end[NA];

    event_t expected_events[$];
    int     item_first;

    function automatic logic [63:0] note_samples(logic [2:0] u, logic [15:0] l);
        logic [63:0] b;
        logic [63:0] s;
        b = 64'(beat) * 64'(l);
        s = 64'(sr) * 64'(l);
        case (u)
            U_BEAT:     return b;
            U_BEAT_16:  return b >> 4;
            U_BEAT_256: return b >> 8;
            U_SEC:      return s;
            U_SEC_16:   return s >> 4;
            U_SEC_256:  return s >> 8;
            default:    return 64'(sr);
        endcase
    endfunction

    task automatic push_event(logic [1:0] ev, logic [7:0] nt, logic [7:0] vel, logic full);
        event_t e;
        e.event_res = ev;
        e.note = nt;
        e.velocity = vel;
        e.table_full = full;
        e.last = 1'b0;
        expected_events.push_back(e);
    endtask

    // mode 0 owner, 1 pitch, 2 expired; survivors keep age order
    task automatic release_notes(int mode, logic [7:0] key);
        int w;
        logic hit;
        w = 0;
        for (int i = 0; i < n_act; i++) begin
            if (mode == 0)
                hit = a_owner[i] == key[5:0];
            else if (mode == 1)
                hit = a_note[i] == key;
            else
                hit = pos >= a_end[i];
            if (hit) begin
                push_event(EV_OFF, a_note[i], 8'd0, 1'b0);
                t_on[a_owner[i]] = 1'b0;
            end else begin
                a_note[w] = a_note[i];
                a_owner[w] = a_owner[i];
                a_end[w] = a_end[i];
                w++;
            end
        end
        n_act = w;
    endtask

    task automatic predict_request();
        int t;
        logic [7:0]  vel;
        logic [2:0]  u;
        logic [15:0] l;
        item_first = expected_events.size();
        t = int'(track);
        if (req_type) begin
            if (!skip_time) begin
                pos = pos + 64'(samples);
                release_notes(2, 8'd0);
            end
        end else if (t < int'(tiu)) begin
            if (note_kind == KIND_OFF) begin
                if (t_on[t])
                    release_notes(0, 8'(t));
            end else if (note_kind == KIND_ON) begin
                release_notes(1, note_value);
                if (has_volume) begin
                    t_vol[t] = volume;
                    t_vs[t] = 1'b1;
                end
                t_note[t] = note_value;
                t_on[t] = 1'b1;
                vel = t_vs[t] ? t_vol[t] : dvol;
                u = has_unit ? unit : (t_us[t] ? t_unit[t] : dunit);
                l = has_length ? length : (t_ls[t] ? t_len[t] : dlen);
                if (n_act < NA) begin
                    a_note[n_act] = note_value;
                    a_owner[n_act] = 6'(t);
                    a_end[n_act] = pos + note_samples(u, l);
                    n_act++;
                    push_event(EV_ON, note_value, vel, 1'b0);
                end else begin
                    push_event(EV_ON, note_value, vel, 1'b1);
                end
            end else if (has_volume && (!t_vs[t] || t_vol[t] != volume)) begin
                t_vol[t] = volume;
                t_vs[t] = 1'b1;
                if (t_on[t])
                    push_event(EV_AFTER, t_note[t], volume, 1'b0);
            end
            if (has_unit) begin
                t_unit[t] = unit;
                t_us[t] = 1'b1;
            end
            if (has_length) begin
                t_len[t] = length;
                t_ls[t] = 1'b1;
            end
        end
        if (expected_events.size() > item_first)
            expected_events[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        event_t exp_ev;
        event_t got;
        if (!rst_n) begin
            sr = RST_SEC_RATE;
            beat = RST_BEAT_LENGTH;
            tiu = RST_TRACKS_IN_USE;
            dvol = RST_DEFAULT_VOLUME;
            dunit = RST_DEFAULT_UNIT;
            dlen = RST_DEFAULT_LENGTH;
            pos = '0;
            n_act = 0;
            for (int i = 0; i < NT; i++) begin
                t_on[i] = 0; t_note[i] = 0; t_vs[i] = 0; t_vol[i] = 0;
                t_us[i] = 0; t_unit[i] = 0; t_ls[i] = 0; t_len[i] = 0;
            end
            expected_events.delete();
            fail_count <= 0;
            event_total <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_SEC_RATE:       sr = pwdata[SR_W-1:0];
                    REG_BEAT_LENGTH:    beat = pwdata[BEAT_W-1:0];
                    REG_TRACKS_IN_USE:  tiu = pwdata[TIU_W-1:0];
                    REG_DEFAULT_VOLUME: dvol = pwdata[7:0];
                    REG_DEFAULT_UNIT:   dunit = pwdata[2:0];
                    REG_DEFAULT_LENGTH: dlen = pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                got.event_res = event_res;
                got.note = note;
                got.velocity = velocity;
                got.table_full = table_full;
                got.last = last;
                event_total <= event_total + 1;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event expected none actual %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (got !== exp_ev) begin
                        $display("%0t: event mismatch expected %p actual %p",
                                 $realtime, exp_ev, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_request();
        end
    end

    assign pending_events = expected_events.size();

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import tnsch_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        in_valid, in_stall;
    logic        req_type;
    logic [5:0]  track;
    logic [1:0]  note_kind;
    logic [7:0]  note_value;
    logic        has_volume;
    logic [7:0]  volume;
    logic        has_unit;
    logic [2:0]  unit;
    logic        has_length;
    logic [15:0] length;
    logic [15:0] samples;
    logic        skip_time;
    logic        out_valid, out_stall;
    logic [1:0]  event_res;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic        table_full, last;
    int          fail_count, pending_events, event_total;
    int          cycle_count;
    int          send_idle_pct, stall_pct;
    int          request_total;
    int          active_tracks;

    localparam int CYCLE_LIMIT = 600000;

    tracker_note_scheduler_core dut (.*);

    note_event_checker chk (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // called at a falling edge; drops any request left on the input first
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_events != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // drives one request from the negedge and returns at the negedge after it
    // is accepted; valid stays up so the next request can follow directly
    task automatic send_request(logic rt, logic [5:0] trk, logic [1:0] kind, logic [7:0] nv,
                                logic hv, logic [7:0] vol, logic hu, logic [2:0] u,
                                logic hl, logic [15:0] ln, logic [15:0] smp, logic sk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt; track <= trk; note_kind <= kind; note_value <= nv;
        has_volume <= hv; volume <= vol; has_unit <= hu; unit <= u;
        has_length <= hl; length <= ln; samples <= smp; skip_time <= sk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        request_total++;
    endtask

    task automatic send_row(int trk, logic [1:0] kind, logic [7:0] nv, logic hv,
                            logic [7:0] vol, logic hu, logic [2:0] u, logic hl,
                            logic [15:0] ln);
        send_request(1'b0, 6'(trk), kind, nv, hv, vol, hu, u, hl, ln,
                     16'($urandom), 1'b0);
    endtask

    task automatic send_tick(logic [15:0] smp, logic sk);
        send_request(1'b1, 6'($urandom), 2'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), 1'($urandom), 3'($urandom), 1'($urandom),
                     16'($urandom), smp, sk);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_row($urandom_range(active_tracks - 1), KIND_ON, 8'($urandom_range(255)),
                     1'($urandom), 8'($urandom_range(128)), 1'($urandom),
                     3'($urandom), 1'($urandom), 16'($urandom_range(40)));
        else if (r < 60)
            send_row($urandom_range(active_tracks - 1), KIND_OFF, 8'($urandom), 0, 0,
                     0, 0, 0, 0);
        else if (r < 70)
            send_row($urandom_range(active_tracks - 1), 2'($urandom_range(1) * 3),
                     8'($urandom), 1'b1, 8'($urandom_range(128)), 1'($urandom),
                     3'($urandom), 1'($urandom), 16'($urandom));
        else if (r < 75)
            send_row($urandom_range(63), 2'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), 1'($urandom), 3'($urandom), 1'($urandom),
                     16'($urandom));
        else
            send_tick(16'($urandom_range(1) ? $urandom_range(20000) : $urandom),
                      ($urandom_range(9) == 0));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycle_count = 0;
        request_total = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; out_stall = 0;
        req_type = 0; track = 0; note_kind = 0; note_value = 0;
        has_volume = 0; volume = 0; has_unit = 0; unit = 0;
        has_length = 0; length = 0; samples = 0; skip_time = 0;
        send_idle_pct = 0; stall_pct = 0;
        active_tracks = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: only track 0 is live
        send_row(0, KIND_ON, 8'd60, 0, 0, 0, 0, 0, 0);
        send_row(1, KIND_ON, 8'd61, 1, 8'd5, 0, 0, 0, 0);
        send_row(0, 2'd0, 8'd0, 1, 8'd128, 0, 0, 0, 0);
        send_row(0, 2'd0, 8'd0, 1, 8'd128, 0, 0, 0, 0);
        send_tick(16'd22050, 1'b1);
        send_tick(16'd22050, 1'b0);
        wait_quiet();

        reg_write(REG_TRACKS_IN_USE, 32'd64);
        reg_write(REG_SEC_RATE, 32'd192000);
        reg_write(REG_BEAT_LENGTH, 32'hFFFFFF);
        reg_write(REG_DEFAULT_VOLUME, 32'd0);
        reg_write(REG_DEFAULT_UNIT, 32'd6);
        reg_write(REG_DEFAULT_LENGTH, 32'hFFFF);
        active_tracks = 64;
        send_row(63, KIND_ON, 8'd255, 0, 0, 0, 0, 0, 0);
        send_row(5, KIND_ON, 8'd0, 1, 8'd0, 1, U_BEAT, 1, 16'hFFFF);
        send_row(6, KIND_ON, 8'd255, 1, 8'd128, 1, 3'd7, 1, 16'd0);
        send_row(5, 2'd0, 8'd0, 1, 8'd77, 0, 0, 0, 0);
        send_row(5, 2'd3, 8'd0, 1, 8'd77, 0, 0, 0, 0);
        send_row(7, KIND_OFF, 8'd0, 0, 0, 0, 0, 0, 0);
        send_row(5, KIND_OFF, 8'd0, 1, 8'd9, 1, U_SEC_16, 1, 16'd3);
        send_row(7, KIND_ON, 8'd12, 0, 0, 1, U_BEAT_16, 1, 16'd1);
        send_row(8, KIND_ON, 8'd13, 0, 0, 1, U_BEAT_256, 1, 16'd1);
        send_row(9, KIND_ON, 8'd14, 0, 0, 1, U_SEC, 1, 16'd1);
        send_row(10, KIND_ON, 8'd15, 0, 0, 1, 3'd3, 1, 16'd9);
        send_tick(16'hFFFF, 1'b0);
        // fill the table past its 32 slots
        for (int i = 0; i < 36; i++)
            send_row(i, KIND_ON, 8'(100 + i), 1, 8'(i), 1, U_SEC, 1, 16'd1000);
        wait_quiet();
        send_tick(16'hFFFF, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                3: begin send_idle_pct = 22; stall_pct = 22; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            wait_quiet();
            reg_write(REG_SEC_RATE, (ph == 4) ? 32'd1 : 32'($urandom_range(1, 192000)));
            reg_write(REG_BEAT_LENGTH, (ph == 4) ? 32'd1 : 32'($urandom_range(1, 50000)));
            active_tracks = (ph == 4) ? 1 : $urandom_range(1, 64);
            reg_write(REG_TRACKS_IN_USE, 32'(active_tracks));
            reg_write(REG_DEFAULT_VOLUME, 32'($urandom_range(128)));
            reg_write(REG_DEFAULT_UNIT, 32'($urandom_range(6)));
            reg_write(REG_DEFAULT_LENGTH, 32'($urandom_range(200)));
            for (int i = 0; i < 20; i++)
                random_request();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        wait_quiet();

        $display("%0d requests sent, %0d events checked over idle/stall phases",
                 request_total, event_total);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/tnsch_pkg.sv
src/tnsch_front.sv
src/tnsch_back.sv
src/tracker_note_scheduler_core.sv
src/tnsch_checker.sv
test/note_event_checker.sv
test/tb_top.sv
